// File: rtl/hse_pkg.sv
// Shared types and constants for the heap sort engine.
package hse_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // one write port and one registered read port on the heap store
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

// File: rtl/hse_cmp.sv
// Shared signed less-than unit used by the sift-down sequencer.
module hse_cmp import hse_pkg::*; (
  input  data_t a,
  input  data_t b,
  output logic  lt
);

  assign lt = (a < b);

endmodule

// File: rtl/hse_ram.sv
// Heap store: one write port, one read port with registered data.
module hse_ram import hse_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output data_t    rdata
);

  data_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/heap_sort_engine_core.sv
// Heap sort engine top level: load, bottom-up heap build, in-place sort, ascending emit.
// Load: one item per cycle while busy is low; an item without last produces no result.
// On last: bottom-up heap build, then sort steps that each retire the maximum and sift down
// one level at a time, bound by the single store read port and compare unit.
// Emit: one result per cycle, n results, each in the cycle after its store read; busy drops with the
// final result. Sync active-low reset clears sequencer, count, drop flag and strobes only.
module heap_sort_engine_core import hse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  data_t in_value,
  input  logic  in_last,
  output logic  out_valid,
  output data_t out_sorted_value,
  output logic  out_final_res,
  output logic  out_overflow
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;   // pick first build parent
  localparam logic [3:0] ST_B_RD  = 4'd2;   // read build parent
  localparam logic [3:0] ST_B_WT  = 4'd3;
  localparam logic [3:0] ST_S_CHK = 4'd4;   // sift: any child left?
  localparam logic [3:0] ST_S_LD  = 4'd5;   // left child arriving
  localparam logic [3:0] ST_S_RD  = 4'd6;   // right child arriving
  localparam logic [3:0] ST_S_DEC = 4'd7;   // move hole down or settle
  localparam logic [3:0] ST_S_END = 4'd8;
  localparam logic [3:0] ST_T_CHK = 4'd9;   // sort loop check
  localparam logic [3:0] ST_T_RD1 = 4'd10;
  localparam logic [3:0] ST_T_RD2 = 4'd11;
  localparam logic [3:0] ST_T_WT  = 4'd12;
  localparam logic [3:0] ST_EMIT  = 4'd13;

  localparam logic PH_BUILD = 1'b0;
  localparam logic PH_SORT  = 1'b1;

  localparam cnt_t CNT_ONE = CNT_W'(1);
  localparam cnt_t CNT_CAP = CNT_W'(CAPACITY);

  logic [3:0]        state_r, state_nxt;
  logic              phase_r, phase_nxt;
  cnt_t              count_r, count_nxt;      // elements stored in this set
  logic              dropped_r, dropped_nxt;
  cnt_t              n_r, n_nxt;              // set size latched on last
  logic [CNT_W-2:0]  p_r, p_nxt;              // build parent position
  cnt_t              m_r, m_nxt;              // current heap size in sort phase
  cnt_t              pos_r, pos_nxt;          // hole position during sift
  cnt_t              size_r, size_nxt;        // sift bound
  cnt_t              c_r, c_nxt;              // chosen child position
  data_t             v_r, v_nxt;              // value being sifted
  data_t             cv_r, cv_nxt;            // chosen child value
  data_t             top_r, top_nxt;          // heap maximum being retired
  addr_t             k_r, k_nxt;              // emit index
  logic              vld_r, vld_nxt;
  logic              fin_r, fin_nxt;
  logic              ovf_r, ovf_nxt;

  mem_req_t          req;
  data_t             rdata;
  data_t             cmp_a, cmp_b;
  logic              cmp_lt;

  logic              full;
  cnt_t              count_inc;
  logic [CNT_W:0]    two_pos;
  cnt_t              lpos;
  addr_t             pos_addr;

  hse_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  hse_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign full      = (count_r == CNT_CAP);
  assign count_inc = full ? count_r : count_r + CNT_ONE;
  assign two_pos   = {pos_r, 1'b0};
  assign lpos      = {pos_r[CNT_W-2:0], 1'b0};
  assign pos_addr  = ADDR_W'(pos_r - CNT_ONE);

  // compare unit input select: child against child, or hole value against child
  always_comb begin
    if (state_r == ST_S_RD) begin
      cmp_a = cv_r;
      cmp_b = rdata;
    end else begin
      cmp_a = v_r;
      cmp_b = cv_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    m_nxt       = m_r;
    pos_nxt     = pos_r;
    size_nxt    = size_r;
    c_nxt       = c_r;
    v_nxt       = v_r;
    cv_nxt      = cv_r;
    top_nxt     = top_r;
    k_nxt       = k_r;
    vld_nxt     = 1'b0;
    fin_nxt     = 1'b0;
    ovf_nxt     = ovf_r;
    req         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!full) begin
            req.we    = 1'b1;
            req.waddr = count_r[ADDR_W-1:0];
            req.wdata = in_value;
          end
          count_nxt   = count_inc;
          dropped_nxt = dropped_r | full;
          if (in_last) begin
            n_nxt     = count_inc;
            state_nxt = ST_PREP;
          end
        end
      end

      ST_PREP: begin
        if (n_r[CNT_W-1:1] == '0) begin
          m_nxt     = n_r;
          phase_nxt = PH_SORT;
          state_nxt = ST_T_CHK;
        end else begin
          p_nxt     = n_r[CNT_W-1:1];
          phase_nxt = PH_BUILD;
          state_nxt = ST_B_RD;
        end
      end

      ST_B_RD: begin
        req.re    = 1'b1;
        req.raddr = ADDR_W'({1'b0, p_r} - CNT_ONE);
        state_nxt = ST_B_WT;
      end

      ST_B_WT: begin
        v_nxt     = rdata;
        pos_nxt   = {1'b0, p_r};
        size_nxt  = n_r;
        state_nxt = ST_S_CHK;
      end

      ST_S_CHK: begin
        if (two_pos > {1'b0, size_r}) begin
          req.we    = 1'b1;
          req.waddr = pos_addr;
          req.wdata = v_r;
          state_nxt = ST_S_END;
        end else begin
          req.re    = 1'b1;
          req.raddr = ADDR_W'(lpos - CNT_ONE);
          state_nxt = ST_S_LD;
        end
      end

      ST_S_LD: begin
        cv_nxt = rdata;
        c_nxt  = lpos;
        // right child only when it lies inside the heap
        if (lpos < size_r) begin
          req.re    = 1'b1;
          req.raddr = lpos[ADDR_W-1:0];
          state_nxt = ST_S_RD;
        end else begin
          state_nxt = ST_S_DEC;
        end
      end

      ST_S_RD: begin
        if (cmp_lt) begin
          cv_nxt = rdata;
          c_nxt  = lpos + CNT_ONE;
        end
        state_nxt = ST_S_DEC;
      end

      ST_S_DEC: begin
        req.we    = 1'b1;
        req.waddr = pos_addr;
        if (cmp_lt) begin
          req.wdata = cv_r;
          pos_nxt   = c_r;
          state_nxt = ST_S_CHK;
        end else begin
          req.wdata = v_r;
          state_nxt = ST_S_END;
        end
      end

      ST_S_END: begin
        if (phase_r == PH_BUILD) begin
          if (p_r == (CNT_W-1)'(1)) begin
            m_nxt     = n_r;
            phase_nxt = PH_SORT;
            state_nxt = ST_T_CHK;
          end else begin
            p_nxt     = p_r - (CNT_W-1)'(1);
            state_nxt = ST_B_RD;
          end
        end else begin
          m_nxt     = m_r - CNT_ONE;
          state_nxt = ST_T_CHK;
        end
      end

      ST_T_CHK: begin
        if (m_r <= CNT_ONE) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_T_RD1;
        end
      end

      ST_T_RD1: begin
        req.re    = 1'b1;
        req.raddr = '0;
        state_nxt = ST_T_RD2;
      end

      ST_T_RD2: begin
        top_nxt   = rdata;
        req.re    = 1'b1;
        req.raddr = ADDR_W'(m_r - CNT_ONE);
        state_nxt = ST_T_WT;
      end

      ST_T_WT: begin
        // retire the maximum; last heap entry becomes the hole value at the root
        v_nxt     = rdata;
        req.we    = 1'b1;
        req.waddr = ADDR_W'(m_r - CNT_ONE);
        req.wdata = top_r;
        pos_nxt   = CNT_ONE;
        size_nxt  = m_r - CNT_ONE;
        state_nxt = ST_S_CHK;
      end

      ST_EMIT: begin
        req.re    = 1'b1;
        req.raddr = k_r;
        vld_nxt   = 1'b1;
        ovf_nxt   = dropped_r;
        if ({1'b0, k_r} == n_r - CNT_ONE) begin
          fin_nxt     = 1'b1;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= PH_BUILD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      vld_r     <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      vld_r     <= vld_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    m_r    <= m_nxt;
    pos_r  <= pos_nxt;
    size_r <= size_nxt;
    c_r    <= c_nxt;
    v_r    <= v_nxt;
    cv_r   <= cv_nxt;
    top_r  <= top_nxt;
    k_r    <= k_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = vld_r;
  assign out_sorted_value = rdata;
  assign out_final_res    = fin_r;
  assign out_overflow     = ovf_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_CAP)
    else $error("element count beyond capacity");

  a_final_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_res |-> out_valid)
    else $error("final flag without result strobe");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_EMIT)
    else $error("result strobe outside emit");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_res |-> !busy && count_r == '0)
    else $error("set not cleared after final result");
`endif

endmodule

// File: bench/tb_heap_sort_engine_core.sv
// Self-checking bench for the heap sort engine: directed sets, random sets, overflow sets.
module tb_heap_sort_engine_core;
  import hse_pkg::*;

  // Extremes of the value field
  localparam data_t V_MIN = 32'sh8000_0000;
  localparam data_t V_MAX = 32'sh7fff_ffff;

  // One sorted item as it leaves the block
  typedef struct packed {
    data_t sorted_value;
    logic  final_res;
    logic  overflow;
  } sorted_item_t;

  // Directed row: stimulus plus, where obvious, the result typed in by hand
  typedef struct packed {
    data_t value;
    logic  last;
    logic  given;
    data_t want_value;
    logic  want_final;
    logic  want_ovf;
  } directed_row_t;

  localparam int N_DIRECTED = 23;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  start;
  logic  busy;
  data_t in_value;
  logic  in_last;
  logic  out_valid;
  data_t out_sorted_value;
  logic  out_final_res;
  logic  out_overflow;

  // Shadow of the heap store (1-based, as the heap is indexed) and the set state
  data_t        heap_image [1:CAPACITY];
  int           set_count;
  bit           set_dropped;
  sorted_item_t sorted_q [$];   // items still owed by the block, oldest first
  int           mismatch_count;
  int           burst_left;

  // Single-item sets carry a typed result; the rest go through the predictor.
  directed_row_t directed_rows [0:N_DIRECTED-1] = '{
    // single-element sets at the extremes
    {V_MIN,              1'b1, 1'b1, V_MIN,      1'b1, 1'b0},
    {V_MAX,              1'b1, 1'b1, V_MAX,      1'b1, 1'b0},
    {32'sd0,             1'b1, 1'b1, 32'sd0,     1'b1, 1'b0},
    {-32'sd1,            1'b1, 1'b1, -32'sd1,    1'b1, 1'b0},
    // two elements, both orders
    {V_MAX,              1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MIN,              1'b1, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MIN,              1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MAX,              1'b1, 1'b0, 32'sd0,     1'b0, 1'b0},
    // ties
    {32'sd7,             1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'sd7,             1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {-32'sd7,            1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'sd7,             1'b1, 1'b0, 32'sd0,     1'b0, 1'b0},
    // extremes mixed, repeated, with the sign boundary either side of zero
    {32'sd0,             1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {-32'sd1,            1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MAX,              1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MIN,              1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'sd1,             1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MAX,              1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {V_MIN,              1'b1, 1'b0, 32'sd0,     1'b0, 1'b0},
    // alternating bit patterns, then the low bit alone and with the sign bit
    {32'sh5555_5555,     1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'shaaaa_aaaa,     1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'sh0000_0001,     1'b0, 1'b0, 32'sd0,     1'b0, 1'b0},
    {32'sh8000_0001,     1'b1, 1'b0, 32'sd0,     1'b0, 1'b0}
  };

  heap_sort_engine_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: a plain heapsort over the shadow heap
  // ---------------------------------------------------------------------------

  // Push the entry at pos down toward its larger child until it dominates both.
  // The right child is only looked at when it lies inside the live heap.
  function automatic void sift_down_from(int pos, int size);
    int    child;
    data_t held;
    bit    settled;
    settled = 1'b0;
    while (!settled && pos * 2 <= size) begin
      child = pos * 2;
      if (child + 1 <= size && heap_image[child] < heap_image[child + 1])
        child = child + 1;
      if (heap_image[pos] < heap_image[child]) begin
        held              = heap_image[pos];
        heap_image[pos]   = heap_image[child];
        heap_image[child] = held;
        pos               = child;
      end else begin
        settled = 1'b1;
      end
    end
  endfunction

  // Take one accepted item; on last, build, sort and queue the ascending results.
  function automatic void predict_sorted(data_t value, logic last);
    int           n;
    data_t        top;
    sorted_item_t entry;
    if (set_count < CAPACITY) begin
      set_count             = set_count + 1;
      heap_image[set_count] = value;
    end else begin
      // store full: item dropped, whole set gets flagged
      set_dropped = 1'b1;
    end
    if (last) begin
      n = set_count;
      for (int p = n / 2; p >= 1; p--)
        sift_down_from(p, n);
      // move the maximum to the tail of the shrinking heap
      for (int s = n; s > 1; s--) begin
        top           = heap_image[1];
        heap_image[1] = heap_image[s];
        heap_image[s] = top;
        sift_down_from(1, s - 1);
      end
      for (int k = 1; k <= n; k++) begin
        entry.sorted_value = heap_image[k];
        entry.final_res    = (k == n);
        entry.overflow     = set_dropped;
        sorted_q.push_back(entry);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Bursts of random
  // length are separated by random gaps; a gap of zero keeps start high, so
  // start is never dropped and raised in the same step.
  task automatic send_item(data_t value, logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_value <= value;
    in_last  <= last;
    start    <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    burst_left = burst_left - 1;
    predict_sorted(value, last);
  endtask

  // Sender stands back until the block has returned everything owed.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  // Random value: extremes, a narrow band for ties, otherwise all 32 bits
  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0:       return V_MIN;
          1:       return V_MAX;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return data_t'($signed($urandom_range(0, 8)) - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobed item is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    sorted_item_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (sorted_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected item: value %0d final %b ovf %b (valid %b)",
                   out_sorted_value, out_final_res, out_overflow, out_valid);
      end else begin
        want = sorted_q.pop_front();
        if (out_valid !== 1'b1 || out_sorted_value !== want.sorted_value ||
            out_final_res !== want.final_res || out_overflow !== want.overflow) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("mismatch: want value %0d final %b ovf %b, got %0d final %b ovf %b",
                     want.sorted_value, want.final_res, want.overflow,
                     out_sorted_value, out_final_res, out_overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int           small_sent;
    int           set_no;
    int           set_size;
    int           guard;
    sorted_item_t entry;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_value       <= '0;
    in_last        <= 1'b0;
    set_count      = 0;
    set_dropped    = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    small_sent     = 0;
    set_no         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; a typed result replaces the predicted one for its row
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(directed_rows[i].value, directed_rows[i].last);
      if (directed_rows[i].given) begin
        entry.sorted_value = directed_rows[i].want_value;
        entry.final_res    = directed_rows[i].want_final;
        entry.overflow     = directed_rows[i].want_ovf;
        sorted_q[sorted_q.size() - 1] = entry;
      end
    end
    // full stop at least once: nothing in flight before random sets begin
    wait_for_drain();

    // Random sets, mostly small. Two large ones: exactly full, and one that
    // runs past the store so the closing item is itself dropped.
    while (small_sent < 75 || set_no < 6) begin
      if (set_no == 2)
        set_size = CAPACITY;
      else if (set_no == 5)
        set_size = CAPACITY + 2;
      else if ($urandom_range(0, 9) == 0)
        set_size = $urandom_range(13, 40);
      else
        set_size = $urandom_range(1, 12);
      if (set_no != 2 && set_no != 5)
        small_sent = small_sent + set_size;
      // now and then a whole set goes in back to back
      if ($urandom_range(0, 4) == 0)
        burst_left = set_size;
      for (int k = 0; k < set_size; k++)
        send_item(pick_value(), k == set_size - 1);
      if ($urandom_range(0, 5) == 0)
        wait_for_drain();
      set_no = set_no + 1;
    end

    // Let the block finish, then a quiet tail to catch stray items
    start <= 1'b0;
    guard = 0;
    while (sorted_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard = guard + 1;
    end
    repeat (64) @(posedge clk);

    if (sorted_q.size() != 0)
      $display("%0d items never arrived", sorted_q.size());
    if (mismatch_count == 0 && sorted_q.size() == 0)
      $display("tb_heap_sort_engine_core: clean");
    else
      $display("tb_heap_sort_engine_core: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_heap_sort_engine_core: errors");
    $finish;
  end

endmodule
